// File: src/hews_pkg.sv
`timescale 1ns / 1ps
package hews_pkg;

  localparam int unsigned COUNT_W  = 31;
  localparam int unsigned BIN_W    = 32;
  localparam int unsigned TOTAL_W  = 40;
  localparam int unsigned SUM_W    = 61;
  localparam int unsigned ENT_W    = 20;
  localparam int unsigned SCORE_W  = 27;
  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned K_W      = 6;
  localparam int unsigned NORM_W   = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 24'd171205;

  localparam logic [0:0] REG_ZETA_WEIGHT = 1'b0;

  // one queued bin after classification
  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic               pos;
    logic               last;
  } item_t;

endpackage

// File: src/hews_front.sv
`timescale 1ns / 1ps
module hews_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          in_data_i,
  input  logic                 in_last_i,
  output logic                 q_valid_o,
  output hews_pkg::item_t      q_item_o,
  input  logic                 q_pop_i
);
  import hews_pkg::*;

  item_t       mem_q [2];
  logic [1:0]  vld_q, vld_d;
  logic        wr_q, wr_d, rd_q, rd_d;
  logic        push;
  item_t       item_in;

  always_comb begin
    item_in.cnt  = in_data_i[COUNT_W-1:0];
    item_in.pos  = !in_data_i[BIN_W-1] && (in_data_i != '0);
    item_in.last = in_last_i;
  end

  assign in_ready_o = !vld_q[wr_q];
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = vld_q[rd_q];
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    vld_d = vld_q;
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (q_pop_i && q_valid_o) begin
      vld_d[rd_q] = 1'b0;
      rd_d        = !rd_q;
    end
    if (push) begin
      vld_d[wr_q] = 1'b1;
      wr_d        = !wr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      vld_q <= vld_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_in;
  end

endmodule

// File: src/hews_log.sv
`timescale 1ns / 1ps
module hews_log #(
  parameter int unsigned LOG_FRAC_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [hews_pkg::TOTAL_W-1:0]             val_i,
  output logic                                     done_o,
  output logic [hews_pkg::K_W+LOG_FRAC_BITS-1:0]   res_o
);
  import hews_pkg::*;

  localparam int unsigned IDX_W = (LOG_FRAC_BITS > 1) ? $clog2(LOG_FRAC_BITS) : 1;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_FRAC = 2'd2;

  logic [1:0]               st_q, st_d;
  logic [TOTAL_W-1:0]       x_q, x_d;
  logic [NORM_W-1:0]        xf_q, xf_d;
  logic [K_W-1:0]           k_q, k_d;
  logic [IDX_W-1:0]         i_q, i_d;
  logic [LOG_FRAC_BITS-1:0] frac_q, frac_d;
  logic                     done_q, done_d;
  logic [2*NORM_W-1:0]      sq;
  logic [NORM_W:0]          t;

  assign sq = {{NORM_W{1'b0}}, xf_q} * {{NORM_W{1'b0}}, xf_q};
  assign t  = sq[2*NORM_W-1:NORM_W-1];

  always_comb begin
    st_d   = st_q;
    x_d    = x_q;
    xf_d   = xf_q;
    k_d    = k_q;
    i_d    = i_q;
    frac_d = frac_q;
    done_d = 1'b0;
    unique case (st_q)
      L_IDLE: begin
        if (start_i) begin
          x_d    = val_i;
          k_d    = K_W'(TOTAL_W - 1);
          frac_d = '0;
          st_d   = L_NORM;
        end
      end
      L_NORM: begin
        if (x_q[TOTAL_W-1]) begin
          xf_d = x_q[TOTAL_W-1:TOTAL_W-NORM_W];
          i_d  = IDX_W'(LOG_FRAC_BITS - 1);
          st_d = L_FRAC;
        end else begin
          x_d = {x_q[TOTAL_W-2:0], 1'b0};
          k_d = k_q - 1'b1;
        end
      end
      L_FRAC: begin
        // square, then renormalize when the square reached two
        if (t[NORM_W]) begin
          xf_d         = t[NORM_W:1];
          frac_d[i_q]  = 1'b1;
        end else begin
          xf_d = t[NORM_W-1:0];
        end
        if (i_q == '0) begin
          st_d   = L_IDLE;
          done_d = 1'b1;
        end else begin
          i_d = i_q - 1'b1;
        end
      end
      default: st_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= L_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    xf_q   <= xf_d;
    k_q    <= k_d;
    i_q    <= i_d;
    frac_q <= frac_d;
  end

  assign done_o = done_q;
  assign res_o  = {k_q, frac_q};

endmodule

// File: src/hews_div.sv
`timescale 1ns / 1ps
module hews_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [hews_pkg::SUM_W-1:0]    num_i,
  input  logic [hews_pkg::TOTAL_W-1:0]  den_i,
  output logic                          done_o,
  output logic [hews_pkg::SUM_W-1:0]    quo_o
);
  import hews_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W);

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SUM_W-1:0]     num_q;
  logic [TOTAL_W-1:0]   den_q, rem_q;
  logic [TOTAL_W:0]     r;
  logic                 ge;

  assign r  = {rem_q, num_q[SUM_W-1]};
  assign ge = r >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      cnt_q <= CNT_W'(SUM_W - 1);
    end else if (busy_q) begin
      rem_q <= ge ? TOTAL_W'(r - {1'b0, den_q}) : r[TOTAL_W-1:0];
      num_q <= {num_q[SUM_W-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// File: src/hews_back.sv
`timescale 1ns / 1ps
module hews_back #(
  parameter int unsigned LOG_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  hews_pkg::item_t                q_item_i,
  output logic                           q_pop_o,
  input  logic [hews_pkg::WEIGHT_W-1:0]  weight_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [hews_pkg::SCORE_W-1:0]   score_o,
  output logic [hews_pkg::ENT_W-1:0]     entropy_o,
  output logic                           empty_o
);
  import hews_pkg::*;

  localparam int unsigned LW     = K_W + LOG_FRAC_BITS;
  localparam int unsigned TERM_W = COUNT_W + LW;
  localparam int unsigned SHR    = (LOG_FRAC_BITS >= 16) ? LOG_FRAC_BITS - 16 : 0;
  localparam int unsigned SHL    = (LOG_FRAC_BITS < 16) ? 16 - LOG_FRAC_BITS : 0;
  localparam int unsigned PROD_W = ENT_W + WEIGHT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BLOG  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_TWAIT = 3'd4;
  localparam logic [2:0] S_SCORE = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]          st_q, st_d;
  logic [TOTAL_W-1:0]  total_q;
  logic [SUM_W-1:0]    sum_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic                last_q;
  logic [TERM_W-1:0]   term_q;
  logic                lg_seen_q, dv_seen_q;
  logic [LW-1:0]       lt_q;
  logic [ENT_W-1:0]    ent_q;
  logic [SCORE_W-1:0]  res_score_q;
  logic                res_empty_q;
  logic                out_valid_q;
  logic [SCORE_W-1:0]  score_q;
  logic [ENT_W-1:0]    entropy_q;
  logic                empty_q;

  logic                lg_start, lg_done, dv_start, dv_done;
  logic [TOTAL_W-1:0]  lg_val;
  logic [LW-1:0]       lg_res;
  logic [SUM_W-1:0]    quo;
  logic [TOTAL_W:0]    tot_sum;
  logic [SUM_W:0]      log_sum;
  logic [SUM_W-1:0]    diff;
  logic [63:0]         ent_w;
  logic [PROD_W-1:0]   prod;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (st_q == S_IDLE) && q_valid_i;
  assign lg_start = (q_pop_o && q_item_i.pos) || ((st_q == S_FIN) && total_q != '0);
  assign dv_start = (st_q == S_FIN) && total_q != '0;
  assign lg_val   = (st_q == S_IDLE) ? TOTAL_W'(q_item_i.cnt) : total_q;

  hews_log #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log (
    .clk_i, .rst_ni, .start_i(lg_start), .val_i(lg_val), .done_o(lg_done), .res_o(lg_res)
  );

  hews_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(sum_q), .den_i(total_q),
    .done_o(dv_done), .quo_o(quo)
  );

  assign tot_sum = {1'b0, total_q} + (TOTAL_W + 1)'(cnt_q);
  assign log_sum = {1'b0, sum_q} + (SUM_W + 1)'(term_q);
  assign diff    = (SUM_W'(lt_q) > quo) ? SUM_W'(lt_q) - quo : '0;
  assign ent_w   = (64'(diff) >> SHR) << SHL;
  assign prod    = ent_q * weight_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.pos)       st_d = S_BLOG;
          else if (q_item_i.last) st_d = S_FIN;
        end
      end
      S_BLOG:  if (lg_done) st_d = S_ACC;
      S_ACC:   st_d = last_q ? S_FIN : S_IDLE;
      S_FIN:   st_d = (total_q == '0) ? S_EMIT : S_TWAIT;
      S_TWAIT: if ((lg_seen_q || lg_done) && (dv_seen_q || dv_done)) st_d = S_SCORE;
      S_SCORE: st_d = S_EMIT;
      S_EMIT:  if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      total_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      lg_seen_q   <= 1'b0;
      dv_seen_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_ACC) begin
        total_q <= tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
        sum_q   <= log_sum[SUM_W] ? '1 : log_sum[SUM_W-1:0];
      end
      if (st_q == S_FIN) begin
        lg_seen_q <= 1'b0;
        dv_seen_q <= 1'b0;
      end else begin
        if (lg_done) lg_seen_q <= 1'b1;
        if (dv_done) dv_seen_q <= 1'b1;
      end
      if (st_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
        total_q     <= '0;
        sum_q       <= '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cnt_q  <= q_item_i.cnt;
      last_q <= q_item_i.last;
    end
    if (st_q == S_BLOG && lg_done) term_q <= cnt_q * lg_res;
    if (lg_done) lt_q <= lg_res;
    if (st_q == S_FIN) begin
      res_empty_q <= (total_q == '0);
      res_score_q <= '0;
      ent_q       <= '0;
    end
    if (st_q == S_TWAIT) ent_q <= (ent_w > 64'((1 << ENT_W) - 1)) ? '1 : ENT_W'(ent_w);
    if (st_q == S_SCORE) begin
      res_score_q <= prod[PROD_W-1] ? '1 : prod[PROD_W-2:16];
    end
    if (st_q == S_EMIT && out_free) begin
      score_q   <= res_score_q;
      entropy_q <= ent_q;
      empty_q   <= res_empty_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign entropy_o   = entropy_q;
  assign empty_o     = empty_q;

endmodule

// File: src/histogram_entropy_weighted_score.sv
`timescale 1ns / 1ps
// Histogram entropy score.
// s_axis carries one bin count per transaction (tdata, signed) and tlast on
// the final bin; counts that are zero or negative add nothing. At the final
// bin one result leaves on m_axis: score and entropy in Q.16 in tdata, the
// empty-histogram flag in tuser. Bins that end no histogram give no result.
// The APB port holds the zeta weight (Q8.16) at address 0.
// A two-entry queue decouples intake from the arithmetic back end.
// A positive bin holds the back end, which pops no further bin until the
// shared log unit is done (one normalize shift or one 32x32 squaring per
// cycle); a non-positive bin is popped without the log unit. The last bin
// also waits for the bit-serial 61-bit by 40-bit divider running beside the
// log of the total.
// Reset clears the queue, both accumulators and the output register, and
// sets the weight to zeta(1.5). While m_axis stalls the result holds; the
// queue keeps taking bins until it fills, then s_axis_tready drops.
module histogram_entropy_weighted_score #(
  parameter int unsigned LOG_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // bin_count[31:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // score[26:0], entropy[46:27], zero[47]
  output logic        m_axis_tuser,   // empty_histogram[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hews_pkg::*;

  item_t                q_item;
  logic                 q_valid, q_pop;
  logic [WEIGHT_W-1:0]  weight_q;
  logic [SCORE_W-1:0]   score;
  logic [ENT_W-1:0]     entropy;
  logic                 empty;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ZETA_WEIGHT) ? 32'(weight_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ZETA_WEIGHT) begin
      weight_q <= pwdata[WEIGHT_W-1:0];
    end
  end

  hews_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata), .in_last_i(s_axis_tlast),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  hews_back #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .weight_i(weight_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .score_o(score), .entropy_o(entropy), .empty_o(empty)
  );

  assign m_axis_tdata = {1'b0, entropy, score};
  assign m_axis_tuser = empty;

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("empty histogram result carries nonzero data");

  a_zero_ent_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && entropy == '0 |-> score == '0)
    else $error("score nonzero with zero entropy");

  a_reset_idle: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule
